>>> hw/rtl/grid_trilinear_interpolator_unit_defines.svh
`ifndef GRID_TRILINEAR_INTERPOLATOR_UNIT_DEFINES_SVH
`define GRID_TRILINEAR_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gti_pkg.sv
`default_nettype none

package gti_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int CELL_W      = 8;
    localparam int BIN_W       = 3;
    localparam int ADDR_W      = 15;
    localparam int STORE_DEPTH = 32768;
    localparam int NEIGHBORS   = 8;

    localparam int GRID_X_DEF      = 16;
    localparam int GRID_Y_DEF      = 16;
    localparam int GRID_Z_DEF      = 16;
    localparam int ENERGY_BINS_DEF = 8;

    // config register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE  = 3'd5;

    localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;

    // input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              ok;
        logic [CELL_W-1:0] cell_no;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    typedef struct packed {
        logic valid;
        logic query;
    } ctl_t;

    // floor((a*(1-f) + b*f)) in Q16.16 == a + floor((b-a)*f / 2^16)
    function automatic logic signed [DATA_W-1:0] lerp(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic        [FRAC_W-1:0] f
    );
        logic signed [DATA_W:0]          diff;
        logic signed [DATA_W+FRAC_W+1:0] prod;
        logic signed [DATA_W:0]          sum;
        diff = (DATA_W+1)'(b) - (DATA_W+1)'(a);
        prod = diff * $signed({1'b0, f});
        sum  = (DATA_W+1)'(a) + (DATA_W+1)'(prod >>> FRAC_W);
        return sum[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gti_ifs.sv
`default_nettype none

interface gti_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [gti_pkg::DATA_W-1:0]   pos_x;
    logic signed [gti_pkg::DATA_W-1:0]   pos_y;
    logic signed [gti_pkg::DATA_W-1:0]   pos_z;
    logic        [gti_pkg::BIN_W-1:0]    energy_bin;
    logic        [gti_pkg::ADDR_W-1:0]   write_address;
    logic signed [gti_pkg::DATA_W-1:0]   write_value;

    modport source (
        output valid, cmd, pos_x, pos_y, pos_z, energy_bin, write_address, write_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, pos_x, pos_y, pos_z, energy_bin, write_address, write_value,
        output ready
    );
endinterface

interface gti_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [gti_pkg::DATA_W-1:0] value;
    logic                              in_range;

    modport source (
        output valid, value, in_range,
        input  ready
    );
    modport sink (
        input  valid, value, in_range,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/gti_ram.sv
`default_nettype none

module gti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gti_axis.sv
`default_nettype none

// One axis: offset, scale, range test. Three register stages.
module gti_axis #(
    parameter int SIZE = 16
) (
    input  wire logic                              clk,
    input  wire logic                              adv,
    input  wire logic signed [gti_pkg::DATA_W-1:0] pos,
    input  wire logic signed [gti_pkg::DATA_W-1:0] origin,
    input  wire logic        [gti_pkg::DATA_W-1:0] scale,
    output      gti_pkg::axis_t                    axis
);

    localparam int DW = gti_pkg::DATA_W;
    localparam int TW = 2 * DW - gti_pkg::FRAC_W;
    localparam logic [TW-1:0] LIM = TW'(SIZE - 1) << gti_pkg::FRAC_W;

    logic signed [DW:0]   d_reg;
    logic [2*DW-1:0]      prod_reg;
    logic                 dpos_reg;
    gti_pkg::axis_t       axis_reg;
    logic [TW-1:0]        t;
    gti_pkg::axis_t       axis_next;

    always_comb
    begin
        t                 = prod_reg[2*DW-1:gti_pkg::FRAC_W];
        axis_next.ok      = dpos_reg && (t != '0) && (t < LIM);
        axis_next.cell_no = t[gti_pkg::FRAC_W +: gti_pkg::CELL_W];
        axis_next.frac    = t[gti_pkg::FRAC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg    <= (DW+1)'(pos) - (DW+1)'(origin);
            prod_reg <= (2*DW)'(scale) * (2*DW)'(d_reg[DW-1:0]);
            dpos_reg <= !d_reg[DW] && (d_reg != '0);
            axis_reg <= axis_next;
        end
    end

    assign axis = axis_reg;

endmodule

`default_nettype wire

>>> hw/rtl/grid_trilinear_interpolator_unit.sv
`default_nettype none

// Channel   Dir  Payload                                         Beat
// in_ch     in   cmd, pos_x/y/z, energy_bin, write_address/value  write or query
// out_ch    out  value, in_range                                  one per query
// cfg       in   cfg_we, cfg_index, cfg_data                      one register write
//
// One beat per cycle while no result is stalled, writes and queries mixed freely.
// A query's result passes stages 1..9 into the output register; writes give none.
// The pipeline moves as a whole; it halts only while a result waits on out_ch.ready.
// The store is 8 replicas of a 32K x 32 single-port RAM, one per cell corner;
// writes hit all 8, so each query reads its 8 corners in the same cycle.
// Reset clears control and config only; store contents are undefined until written.
module grid_trilinear_interpolator_unit #(
    parameter int GRID_X      = gti_pkg::GRID_X_DEF,
    parameter int GRID_Y      = gti_pkg::GRID_Y_DEF,
    parameter int GRID_Z      = gti_pkg::GRID_Z_DEF,
    parameter int ENERGY_BINS = gti_pkg::ENERGY_BINS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    gti_in_if.sink                                 in_ch,
    gti_out_if.source                              out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [gti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gti_pkg::DATA_W-1:0]        cfg_data
);

    localparam int DW = gti_pkg::DATA_W;
    localparam int AW = gti_pkg::ADDR_W;
    localparam int FW = gti_pkg::FRAC_W;
    localparam int NB = gti_pkg::NEIGHBORS;

    // corner offsets in the flat store, modulo store depth
    localparam logic [AW-1:0] OFF_Z = AW'(1);
    localparam logic [AW-1:0] OFF_Y = AW'(GRID_Z);
    localparam logic [AW-1:0] OFF_X = AW'(GRID_Y * GRID_Z);

    // ---- config registers ----
    logic signed [DW-1:0] x_origin_reg, y_origin_reg, z_origin_reg;
    logic        [DW-1:0] x_scale_reg, y_scale_reg, z_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            z_origin_reg <= '0;
            x_scale_reg  <= gti_pkg::SCALE_RESET;
            y_scale_reg  <= gti_pkg::SCALE_RESET;
            z_scale_reg  <= gti_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gti_pkg::CFG_X_ORIGIN: x_origin_reg <= cfg_data;
                gti_pkg::CFG_Y_ORIGIN: y_origin_reg <= cfg_data;
                gti_pkg::CFG_Z_ORIGIN: z_origin_reg <= cfg_data;
                gti_pkg::CFG_X_SCALE:  x_scale_reg  <= cfg_data;
                gti_pkg::CFG_Y_SCALE:  y_scale_reg  <= cfg_data;
                gti_pkg::CFG_Z_SCALE:  z_scale_reg  <= cfg_data;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ---- pipeline control ----
    // stages 1..9; stage 9 is the output register
    gti_pkg::ctl_t ctl_reg [1:9];
    logic          out_busy;
    logic          adv;

    assign out_busy    = ctl_reg[9].valid && ctl_reg[9].query;
    assign adv         = !out_busy || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 9; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            ctl_reg[1].valid <= in_ch.valid;
            ctl_reg[1].query <= in_ch.cmd == gti_pkg::CMD_QUERY;
            for (int i = 2; i <= 9; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // ---- stage 1: input capture ----
    logic signed [DW-1:0]             pos_x_reg, pos_y_reg, pos_z_reg;
    logic [gti_pkg::BIN_W-1:0]        bin_reg [1:4];
    logic [AW-1:0]                    waddr_reg [1:5];
    logic [DW-1:0]                    wval_reg [1:5];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x_reg    <= in_ch.pos_x;
            pos_y_reg    <= in_ch.pos_y;
            pos_z_reg    <= in_ch.pos_z;
            bin_reg[1]   <= in_ch.energy_bin;
            waddr_reg[1] <= in_ch.write_address;
            wval_reg[1]  <= in_ch.write_value;
            for (int i = 2; i <= 4; i++)
            begin
                bin_reg[i] <= bin_reg[i-1];
            end
            for (int i = 2; i <= 5; i++)
            begin
                waddr_reg[i] <= waddr_reg[i-1];
                wval_reg[i]  <= wval_reg[i-1];
            end
        end
    end

    // ---- stages 2..4: axis mapping ----
    gti_pkg::axis_t ax_x, ax_y, ax_z;

    gti_axis #(.SIZE(GRID_X)) u_axis_x (
        .clk(clk), .adv(adv), .pos(pos_x_reg), .origin(x_origin_reg),
        .scale(x_scale_reg), .axis(ax_x)
    );
    gti_axis #(.SIZE(GRID_Y)) u_axis_y (
        .clk(clk), .adv(adv), .pos(pos_y_reg), .origin(y_origin_reg),
        .scale(y_scale_reg), .axis(ax_y)
    );
    gti_axis #(.SIZE(GRID_Z)) u_axis_z (
        .clk(clk), .adv(adv), .pos(pos_z_reg), .origin(z_origin_reg),
        .scale(z_scale_reg), .axis(ax_z)
    );

    // ---- stage 4 -> 5: flat base index and range flag ----
    logic [AW-1:0] base_next;
    logic          ok_next;
    logic [AW-1:0] base_reg;
    logic          ok_reg [5:9];
    logic [FW-1:0] fx_reg [5:8];
    logic [FW-1:0] fy_reg [5:7];
    logic [FW-1:0] fz_reg [5:6];

    always_comb
    begin
        base_next = AW'(AW'(bin_reg[4]) * AW'(GRID_X)) + AW'(ax_x.cell_no);
        base_next = AW'(base_next * AW'(GRID_Y)) + AW'(ax_y.cell_no);
        base_next = AW'(base_next * AW'(GRID_Z)) + AW'(ax_z.cell_no);
        ok_next   = ax_x.ok && ax_y.ok && ax_z.ok
                    && (7'(bin_reg[4]) < 7'(ENERGY_BINS));
    end

    // ---- stage 5: store access (write to all replicas, or 8 corner reads) ----
    logic                   ram_we;
    logic [AW-1:0]          ram_addr [NB];
    logic [DW-1:0]          ram_rdata [NB];

    assign ram_we = adv && ctl_reg[5].valid && !ctl_reg[5].query;

    // corner k: bit 2 = x+1, bit 1 = y+1, bit 0 = z+1
    for (genvar k = 0; k < NB; k++)
    begin : g_bank
        logic [AW-1:0] rd_addr;
        assign rd_addr = base_reg
                         + ((((k >> 2) & 1) != 0) ? OFF_X : '0)
                         + ((((k >> 1) & 1) != 0) ? OFF_Y : '0)
                         + (((k & 1) != 0) ? OFF_Z : '0);
        assign ram_addr[k] = ram_we ? waddr_reg[5] : rd_addr;

        gti_ram #(.WIDTH(DW), .DEPTH(gti_pkg::STORE_DEPTH)) u_ram (
            .clk(clk), .en(adv), .we(ram_we), .addr(ram_addr[k]),
            .wdata(wval_reg[5]), .rdata(ram_rdata[k])
        );
    end

    // ---- stages 7..9: z, y, x blends ----
    logic signed [DW-1:0] lz_reg [4];
    logic signed [DW-1:0] ly_reg [2];
    logic signed [DW-1:0] value_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base_reg  <= base_next;
            ok_reg[5] <= ok_next;
            fx_reg[5] <= ax_x.frac;
            fy_reg[5] <= ax_y.frac;
            fz_reg[5] <= ax_z.frac;
            for (int i = 6; i <= 9; i++)
            begin
                ok_reg[i] <= ok_reg[i-1];
            end
            for (int i = 6; i <= 8; i++)
            begin
                fx_reg[i] <= fx_reg[i-1];
            end
            for (int i = 6; i <= 7; i++)
            begin
                fy_reg[i] <= fy_reg[i-1];
            end
            fz_reg[6] <= fz_reg[5];

            // stage 6 has ram data; stage 7 holds the z blends
            for (int j = 0; j < 4; j++)
            begin
                lz_reg[j] <= gti_pkg::lerp(ram_rdata[2*j], ram_rdata[2*j+1], fz_reg[6]);
            end
            // stage 8: along y
            ly_reg[0] <= gti_pkg::lerp(lz_reg[0], lz_reg[1], fy_reg[7]);
            ly_reg[1] <= gti_pkg::lerp(lz_reg[2], lz_reg[3], fy_reg[7]);
        end
    end

    // ---- stage 9: x blend into the output register ----
    logic signed [DW-1:0] value_reg;

    assign value_next = ok_reg[8] ? gti_pkg::lerp(ly_reg[0], ly_reg[1], fx_reg[8]) : '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= value_next;
        end
    end

    assign out_ch.valid    = out_busy;
    assign out_ch.value    = value_reg;
    assign out_ch.in_range = ok_reg[9];

endmodule

`default_nettype wire

>>> hw/rtl/gti_checker.sv
`default_nettype none

`include "grid_trilinear_interpolator_unit_defines.svh"

module gti_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic signed [gti_pkg::DATA_W-1:0] value,
    input wire logic                              in_range
);

    // a stalled result stays put
    `GTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(in_range), "stalled result changed")

    // out-of-range queries answer zero
    `GTI_ASSERT_NOW(a_zero_oor, out_valid && !in_range, value == '0, "out-of-range result not zero")

    // input is held off only by a waiting result
    `GTI_ASSERT_NOW(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready), "input ready not tied to output stall")

endmodule

bind grid_trilinear_interpolator_unit gti_checker u_gti_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .value(out_ch.value),
    .in_range(out_ch.in_range)
);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

// Checks the trilinear flux interpolator end to end. An initial block fills a
// queue of write and query beats phase by phase, rewriting the origin and
// scale registers between phases while the block is idle. A clocked driver
// feeds the beats with random gaps; an in-line model of the grid predicts each
// query's value and in_range when its beat is taken; a clocked monitor stalls
// the output at random and compares every result with the oldest prediction.
module testbench;
    import gti_pkg::*;

    localparam int NX = GRID_X_DEF;
    localparam int NY = GRID_Y_DEF;
    localparam int NZ = GRID_Z_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic              cmd;
        logic [DATA_W-1:0] pos_x;
        logic [DATA_W-1:0] pos_y;
        logic [DATA_W-1:0] pos_z;
        logic [BIN_W-1:0]  energy_bin;
        logic [ADDR_W-1:0] write_address;
        logic [DATA_W-1:0] write_value;
    } beat_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              in_range;
    } flux_t;

    logic clk;
    logic rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    gti_in_if  in_ch();
    gti_out_if out_ch();

    grid_trilinear_interpolator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model copy of grid and registers
    logic [DATA_W-1:0] grid_model [STORE_DEPTH];
    bit                filled     [STORE_DEPTH]; // generator side: entry written
    longint            org [3];
    longint unsigned   scl [3];

    beat_t  pending_beats [$];
    flux_t  flux_expected [$];
    int     errors;
    int     quiet_cycles;
    bit     calm;          // no idling on either side while set

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---- model -------------------------------------------------------------

    // Maps one axis to grid units; 0 when the position falls outside.
    function automatic bit grid_axis(input logic [DATA_W-1:0] pos, input int ax,
                                     input int size, output int cell_no, output int frac);
        longint          d;
        longint unsigned t;
        d = longint'($signed(pos)) - org[ax];
        cell_no = 0;
        frac = 0;
        if (d <= 0)
            return 1'b0;
        t = (scl[ax] * longint'(d)) >> 16;
        if (t == 0 || t >= (longint'(size - 1) << 16))
            return 1'b0;
        cell_no = int'(t >> 16);
        frac = int'(t & 64'hFFFF);
        return 1'b1;
    endfunction

    function automatic int flat_index(input int e, input int x, input int y, input int z);
        return (((e * NX + x) * NY + y) * NZ + z) % STORE_DEPTH;
    endfunction

    function automatic longint blend(input longint a, input longint b, input int f);
        // floor division by 2^16 via arithmetic shift
        return (a * (65536 - f) + b * f) >>> 16;
    endfunction

    function automatic longint corner(input int e, input int x, input int y, input int z);
        return longint'($signed(grid_model[flat_index(e, x, y, z)]));
    endfunction

    function automatic flux_t interpolate(input beat_t b);
        flux_t  r;
        int     xl, yl, zl, xf, yf, zf, e;
        longint i1, i2, j1, j2, w1, w2;
        r.value = '0;
        r.in_range = 1'b0;
        e = int'(b.energy_bin);
        if (e >= ENERGY_BINS_DEF)
            return r;
        if (!grid_axis(b.pos_x, 0, NX, xl, xf)) return r;
        if (!grid_axis(b.pos_y, 1, NY, yl, yf)) return r;
        if (!grid_axis(b.pos_z, 2, NZ, zl, zf)) return r;
        // four along z, two along y, one along x
        i1 = blend(corner(e, xl, yl, zl),         corner(e, xl, yl, zl + 1), zf);
        i2 = blend(corner(e, xl, yl + 1, zl),     corner(e, xl, yl + 1, zl + 1), zf);
        j1 = blend(corner(e, xl + 1, yl, zl),     corner(e, xl + 1, yl, zl + 1), zf);
        j2 = blend(corner(e, xl + 1, yl + 1, zl), corner(e, xl + 1, yl + 1, zl + 1), zf);
        w1 = blend(i1, i2, yf);
        w2 = blend(j1, j2, yf);
        r.value = DATA_W'(blend(w1, w2, xf));
        r.in_range = 1'b1;
        return r;
    endfunction

    // ---- stimulus helpers --------------------------------------------------

    task automatic push_write(input int addr, input logic [DATA_W-1:0] v);
        beat_t b;
        b.cmd = CMD_WRITE;
        b.pos_x = $urandom();
        b.pos_y = $urandom();
        b.pos_z = $urandom();
        b.energy_bin = $urandom_range(0, 7);
        b.write_address = ADDR_W'(addr);
        b.write_value = v;
        filled[addr] = 1'b1;
        pending_beats.push_back(b);
    endtask

    // Queues a query, first writing any of its eight corners not yet written.
    task automatic push_query(input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                              input logic [DATA_W-1:0] pz, input logic [BIN_W-1:0] eb);
        beat_t b;
        int    xl, yl, zl, xf, yf, zf, k, a;
        bit    in_grid;
        in_grid = int'(eb) < ENERGY_BINS_DEF && grid_axis(px, 0, NX, xl, xf)
                  && grid_axis(py, 1, NY, yl, yf) && grid_axis(pz, 2, NZ, zl, zf);
        if (in_grid)
        begin
            for (k = 0; k < NEIGHBORS; k++)
            begin
                a = flat_index(int'(eb), xl + k[2], yl + k[1], zl + k[0]);
                if (!filled[a])
                    push_write(a, $urandom());
            end
        end
        b.cmd = CMD_QUERY;
        b.pos_x = px;
        b.pos_y = py;
        b.pos_z = pz;
        b.energy_bin = eb;
        b.write_address = $urandom();
        b.write_value = $urandom();
        pending_beats.push_back(b);
    endtask

    // Position whose mapped coordinate spreads over and just past the grid.
    function automatic logic [DATA_W-1:0] aimed_pos(input int ax, input int size);
        longint unsigned t, d;
        if (scl[ax] == 0 || $urandom_range(0, 9) == 0)
            return $urandom();
        t = $urandom_range(0, size << 16);
        d = ((t << 16) + scl[ax] - 1) / scl[ax];
        if ($urandom_range(0, 7) == 0)
            d = d + $urandom_range(0, 3) - 1;
        return DATA_W'(org[ax] + longint'(d));
    endfunction

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_X_ORIGIN: org[0] = longint'($signed(v));
            CFG_Y_ORIGIN: org[1] = longint'($signed(v));
            CFG_Z_ORIGIN: org[2] = longint'($signed(v));
            CFG_X_SCALE:  scl[0] = v;
            CFG_Y_SCALE:  scl[1] = v;
            CFG_Z_SCALE:  scl[2] = v;
            default: ;
        endcase
    endtask

    task automatic write_regs(input logic [DATA_W-1:0] xo, input logic [DATA_W-1:0] yo,
                              input logic [DATA_W-1:0] zo, input logic [DATA_W-1:0] xs,
                              input logic [DATA_W-1:0] ys, input logic [DATA_W-1:0] zs);
        set_reg(CFG_X_ORIGIN, xo);
        set_reg(CFG_Y_ORIGIN, yo);
        set_reg(CFG_Z_ORIGIN, zo);
        set_reg(CFG_X_SCALE, xs);
        set_reg(CFG_Y_SCALE, ys);
        set_reg(CFG_Z_SCALE, zs);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender holds off until the block has drained completely.
    task automatic drain();
        wait (pending_beats.size() == 0 && !in_ch.valid && flux_expected.size() == 0);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_scale();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(32'h0000_4000, 32'h0004_0000);
            2: return $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
            default: return SCALE_RESET;
        endcase
    endfunction

    // ---- sequence ----------------------------------------------------------

    initial
    begin
        int p, n, target;
        logic [DATA_W-1:0] ones;
        ones = '1;
        errors = 0;
        calm = 1'b0;
        org = '{0, 0, 0};
        scl = '{65536, 65536, 65536};
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: store ends, extreme samples, grid edges, out-of-range
        push_write(0, 32'h7FFF_FFFF);
        push_write(STORE_DEPTH - 1, 32'h8000_0000);
        push_write(1, 32'h8000_0000);
        push_write(16, 32'h7FFF_FFFF);
        push_query(32'd1, 32'd1, 32'd1, 3'd0);                         // just above lower edge
        push_query(32'h000E_FFFF, 32'h000E_FFFF, 32'h000E_FFFF, 3'd7); // just below upper edge
        push_query(32'h000F_0000, 32'h0001_0000, 32'h0001_0000, 3'd2); // on upper edge
        push_query(32'd0, 32'h0001_0000, 32'h0001_0000, 3'd1);         // on origin
        push_query(ones, 32'h0001_0000, 32'h0001_0000, 3'd3);          // below origin
        push_query(32'h0001_0000, 32'h8000_0000, 32'h0001_0000, 3'd4);
        push_query(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 3'd5);
        push_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 3'd0);
        push_query(32'h0007_8000, 32'h0003_4000, 32'h000C_C000, 3'd6);
        drain();

        // extreme origins and scales, including a zero scale
        write_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd1, 32'hFFFF_FFFF, 32'h0);
        push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd5, 3'd0);
        push_query(32'h0000_0000, 32'h0, 32'h0001_0000, 3'd1);
        drain();
        write_regs(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000);
        push_query(32'h7FFF_FFFF, 32'd7, 32'h0, 3'd0);
        push_query(32'h0, 32'd14, 32'h7FFF_FFFF, 3'd1);
        push_query(32'h0, 32'd15, 32'h0001_0000, 3'd2);               // scale overflow past grid
        drain();

        for (p = 0; p < 7; p++)
        begin
            case (p)
                0: write_regs($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                              $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                              $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                              rand_scale(), rand_scale(), rand_scale());
                1: write_regs(32'h8000_0000, $urandom(), 32'h7FFF_0000,
                              32'd1, 32'hFFFF_FFFF, rand_scale());
                6: write_regs(32'h0, 32'h0, 32'h0, SCALE_RESET, SCALE_RESET, SCALE_RESET);
                default: write_regs($urandom(), $urandom(), $urandom(),
                                    rand_scale(), rand_scale(), rand_scale());
            endcase
            calm = (p == 3);
            target = pending_beats.size() + 245;
            n = 0;
            while (pending_beats.size() < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    push_write($urandom_range(0, STORE_DEPTH - 1), $urandom());
                else
                    push_query(aimed_pos(0, NX), aimed_pos(1, NY), aimed_pos(2, NZ),
                               $urandom_range(0, 7));
                n++;
            end
            drain();
        end

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // ---- driver: feeds pending beats, predicts on each taken beat -------

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_WRITE;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
        in_ch.energy_bin = '0;
        in_ch.write_address = '0;
        in_ch.write_value = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        beat_t nb;
        beat_t cur;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                cur.cmd = in_ch.cmd;
                cur.pos_x = in_ch.pos_x;
                cur.pos_y = in_ch.pos_y;
                cur.pos_z = in_ch.pos_z;
                cur.energy_bin = in_ch.energy_bin;
                cur.write_address = in_ch.write_address;
                cur.write_value = in_ch.write_value;
                if (cur.cmd == CMD_WRITE)
                    grid_model[cur.write_address] = cur.write_value;
                else
                    flux_expected.push_back(interpolate(cur));
            end
            // free to present a new beat once the current one is gone
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    nb = pending_beats.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.cmd <= nb.cmd;
                    in_ch.pos_x <= nb.pos_x;
                    in_ch.pos_y <= nb.pos_y;
                    in_ch.pos_z <= nb.pos_z;
                    in_ch.energy_bin <= nb.energy_bin;
                    in_ch.write_address <= nb.write_address;
                    in_ch.write_value <= nb.write_value;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---- monitor: random back-pressure, compare with oldest prediction ----

    always @(posedge clk or negedge rst_n)
    begin
        flux_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
            if (out_ch.valid && out_ch.ready)
            begin
                if (flux_expected.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h in_range=%b",
                             $time, out_ch.value, out_ch.in_range);
                    errors++;
                end
                else
                begin
                    want = flux_expected.pop_front();
                    if (out_ch.value !== want.value)
                    begin
                        $display("%0t: value expected %h actual %h",
                                 $time, want.value, out_ch.value);
                        errors++;
                    end
                    if (out_ch.in_range !== want.in_range)
                    begin
                        $display("%0t: in_range expected %b actual %b",
                                 $time, want.in_range, out_ch.in_range);
                        errors++;
                    end
                end
            end
        end
    end

    // ---- watchdog: cycles with no beat on either channel ------------------

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/gti_pkg.sv
hw/rtl/gti_ifs.sv
hw/rtl/gti_ram.sv
hw/rtl/gti_axis.sv
hw/rtl/grid_trilinear_interpolator_unit.sv
hw/rtl/gti_checker.sv
test/testbench.sv
